>>> rtl/scr_pkg.sv
// Shared types, constants and arithmetic helpers of the stereo comb reverb.
package scr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LINE_DEPTH  = 4096;
  localparam int ADDR_W      = $clog2(LINE_DEPTH);
  localparam int FRAC_BITS   = 15;
  localparam int COEF_BITS   = 16;
  localparam int DELAY_BITS  = 13;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int MUL_W       = ((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS) + 1;
  localparam int PROD_W      = 2 * MUL_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MUL_W-1:0]       mul_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [PROD_W:0]        wide_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  localparam logic [COEF_BITS-1:0] ONE_Q15 = COEF_BITS'(1) << FRAC_BITS;
  localparam wide_t HALF_LSB = wide_t'(1) <<< (FRAC_BITS - 1);
  localparam wide_t SAT_HI   = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - wide_t'(1);
  localparam wide_t SAT_LO   = -SAT_HI - wide_t'(1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1,
    REG_SEND  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FB,
    ST_MIX_DRY,
    ST_MIX_WET,
    ST_SUM,
    ST_WB
  } state_t;

  // Shift right by the fraction width with round half up.
  function automatic wide_t round_q15(input wide_t v);
    wide_t t;
    t = v + HALF_LSB;
    return t >>> FRAC_BITS;
  endfunction

  // Clamp to the signed sample range.
  function automatic sample_t sat_sample(input wide_t v);
    wide_t c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

endpackage

>>> rtl/stereo_comb_reverb_unit.sv
// Stereo feedback comb reverb: sequencer, shared multiplier and delay line memories.
// Each stereo pair passes an accept state, a memory read state, per channel the states FB,
// MIX_DRY, MIX_WET and SUM on the shared multiplier (three products and a sum), and a write-back
// that waits for a free output register; a new pair is accepted only after its write-back.
// Reset (rst_n low, synchronous) restores the register defaults and empties the delay lines
// at once: a fill count marks entries never written since reset, and those read as zero.
module stereo_comb_reverb_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [scr_pkg::SAMPLE_BITS-1:0] in_left,
  input  logic signed [scr_pkg::SAMPLE_BITS-1:0] in_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [scr_pkg::SAMPLE_BITS-1:0] out_left,
  output logic signed [scr_pkg::SAMPLE_BITS-1:0] out_right,
  input  logic                          cfg_we,
  input  logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scr_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int SB = scr_pkg::SAMPLE_BITS;
  localparam int AW = scr_pkg::ADDR_W;

  // Control state.
  scr_pkg::state_t state_r, state_nxt;
  logic            ch_r, ch_nxt;
  scr_pkg::addr_t  ptr_r, ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Configuration registers.
  logic [scr_pkg::DELAY_BITS-1:0] delay_r, delay_nxt;
  logic signed [scr_pkg::COEF_BITS-1:0] gain_r, gain_nxt;
  logic [scr_pkg::COEF_BITS-1:0]  send_r, send_nxt;

  // Payload registers of the item in flight.
  scr_pkg::addr_t  wr_r, wr_nxt;
  scr_pkg::addr_t  rd_r, rd_nxt;
  scr_pkg::sample_t in_l_r, in_l_nxt;
  scr_pkg::sample_t in_r_r, in_r_nxt;
  scr_pkg::sample_t wet_r, wet_nxt;
  scr_pkg::sample_t res_l_r, res_l_nxt;
  scr_pkg::sample_t res_r_r, res_r_nxt;
  scr_pkg::sample_t out_l_r, out_l_nxt;
  scr_pkg::sample_t out_r_r, out_r_nxt;
  scr_pkg::prod_t  prod_r;
  scr_pkg::wide_t  acc_r, acc_nxt;

  // Memory ports.
  logic            dry_we, wet_we, line_re;
  logic [2*SB-1:0] dry_q, wet_q;

  // Datapath helpers.
  scr_pkg::addr_t                wr_inc;
  logic [scr_pkg::COEF_BITS-1:0] send_eff, send_inv;
  scr_pkg::sample_t cur_dry, dry_mem, wet_mem, dry_del, wet_del, mix_out;
  logic             rd_valid;
  scr_pkg::mul_t    mul_a, mul_b;
  scr_pkg::prod_t   mul_p;

  // Left sample in the low half of each memory word, right sample in the high half.
  scr_ram #(.WIDTH(2 * SB), .DEPTH(scr_pkg::LINE_DEPTH)) u_dry_line (
    .clk   (clk),
    .we    (dry_we),
    .waddr (wr_r),
    .wdata ({in_r_r, in_l_r}),
    .re    (line_re),
    .raddr (rd_r),
    .rdata (dry_q)
  );

  scr_ram #(.WIDTH(2 * SB), .DEPTH(scr_pkg::LINE_DEPTH)) u_wet_line (
    .clk   (clk),
    .we    (wet_we),
    .waddr (wr_r),
    .wdata ({res_r_r, res_l_r}),
    .re    (line_re),
    .raddr (rd_r),
    .rdata (wet_q)
  );

  // Send above one saturates to fully wet.
  assign send_eff = (send_r > scr_pkg::ONE_Q15) ? scr_pkg::ONE_Q15 : send_r;
  assign send_inv = scr_pkg::ONE_Q15 - send_eff;

  assign wr_inc  = ptr_r + scr_pkg::addr_t'(1);
  assign cur_dry = ch_r ? in_r_r : in_l_r;
  assign dry_mem = ch_r ? dry_q[2*SB-1:SB] : dry_q[SB-1:0];
  assign wet_mem = ch_r ? wet_q[2*SB-1:SB] : wet_q[SB-1:0];

  // The writes since reset filled entries 1 up to the fill count, wrapping; once the count
  // saturates at the line depth every entry holds data.
  assign rd_valid = cnt_r[AW] | ((rd_r != '0) && ({1'b0, rd_r} <= cnt_r));

  // A zero delay reads the entry this item just wrote, which is the current dry sample.
  // The wet entry at that place is still the one from a full line ago.
  assign dry_del = (rd_r == wr_r) ? cur_dry : (rd_valid ? dry_mem : '0);
  assign wet_del = rd_valid ? wet_mem : '0;

  // The one shared multiplier; its product is registered before any use.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      scr_pkg::ST_FB: begin
        mul_a = scr_pkg::mul_t'(gain_r);
        mul_b = scr_pkg::mul_t'(wet_del);
      end
      scr_pkg::ST_MIX_DRY: begin
        mul_a = scr_pkg::mul_t'(cur_dry);
        mul_b = scr_pkg::mul_t'(send_inv);
      end
      scr_pkg::ST_MIX_WET: begin
        mul_a = scr_pkg::mul_t'(wet_r);
        mul_b = scr_pkg::mul_t'(send_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The accumulator already carries the rounding offset, so only the shift remains.
  assign mix_out = scr_pkg::sat_sample((acc_r + scr_pkg::wide_t'(prod_r)) >>>
                                       scr_pkg::FRAC_BITS);

  // Sequencer: next state, configuration writes and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    delay_nxt     = delay_r;
    gain_nxt      = gain_r;
    send_nxt      = send_r;
    wr_nxt        = wr_r;
    rd_nxt        = rd_r;
    in_l_nxt      = in_l_r;
    in_r_nxt      = in_r_r;
    wet_nxt       = wet_r;
    res_l_nxt     = res_l_r;
    res_r_nxt     = res_r_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    acc_nxt       = acc_r;
    in_ready      = 1'b0;
    dry_we        = 1'b0;
    wet_we        = 1'b0;
    line_re       = 1'b0;

    // A result leaves the output register on its transfer.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        scr_pkg::REG_DELAY: delay_nxt = cfg_wdata[scr_pkg::DELAY_BITS-1:0];
        scr_pkg::REG_GAIN:  gain_nxt  = cfg_wdata[scr_pkg::COEF_BITS-1:0];
        scr_pkg::REG_SEND:  send_nxt  = cfg_wdata[scr_pkg::COEF_BITS-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      scr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Advance the write pointer; the delay is taken modulo the line depth.
          in_l_nxt  = in_left;
          in_r_nxt  = in_right;
          ptr_nxt   = wr_inc;
          wr_nxt    = wr_inc;
          rd_nxt    = wr_inc - delay_r[AW-1:0];
          ch_nxt    = 1'b0;
          state_nxt = scr_pkg::ST_READ;
        end
      end
      scr_pkg::ST_READ: begin
        // Store the dry pair and fetch both delayed pairs.
        dry_we    = 1'b1;
        line_re   = 1'b1;
        state_nxt = scr_pkg::ST_FB;
      end
      scr_pkg::ST_FB: begin
        state_nxt = scr_pkg::ST_MIX_DRY;
      end
      scr_pkg::ST_MIX_DRY: begin
        // The feedback product is ready: form the saturated wet sample.
        wet_nxt   = scr_pkg::sat_sample(scr_pkg::wide_t'(dry_del) +
                                        scr_pkg::round_q15(scr_pkg::wide_t'(prod_r)));
        state_nxt = scr_pkg::ST_MIX_WET;
      end
      scr_pkg::ST_MIX_WET: begin
        acc_nxt   = scr_pkg::wide_t'(prod_r) + scr_pkg::HALF_LSB;
        state_nxt = scr_pkg::ST_SUM;
      end
      scr_pkg::ST_SUM: begin
        if (ch_r) begin
          res_r_nxt = mix_out;
          state_nxt = scr_pkg::ST_WB;
        end else begin
          res_l_nxt = mix_out;
          ch_nxt    = 1'b1;
          state_nxt = scr_pkg::ST_FB;
        end
      end
      scr_pkg::ST_WB: begin
        // Hold here while the previous result still waits for its transfer.
        if (!out_valid_r || out_ready) begin
          wet_we        = 1'b1;
          out_l_nxt     = res_l_r;
          out_r_nxt     = res_r_r;
          out_valid_nxt = 1'b1;
          if (!cnt_r[AW]) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = scr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scr_pkg::ST_IDLE;
      ch_r        <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      delay_r     <= scr_pkg::DELAY_BITS'(1);
      gain_r      <= '0;
      send_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      delay_r     <= delay_nxt;
      gain_r      <= gain_nxt;
      send_r      <= send_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_r    <= wr_nxt;
    rd_r    <= rd_nxt;
    in_l_r  <= in_l_nxt;
    in_r_r  <= in_r_nxt;
    wet_r   <= wet_nxt;
    res_l_r <= res_l_nxt;
    res_r_r <= res_r_nxt;
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= mul_p;
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_l_r;
  assign out_right = out_r_r;

endmodule

>>> rtl/scr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
